[src/flcm_pkg.sv]
// ============================================================================
// flcm_pkg: shared types and codes of the free-list chain memory
// Field widths, command and status codes, and the item and result records
// that pass between the stream ports and the chain engine.
// ============================================================================
package flcm_pkg;

    localparam int CMD_W    = 3;
    localparam int ADDR_W   = 6;
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int GSIZE_W  = 7;
    localparam int STATUS_W = 2;
    localparam int HEAD_W   = 7;
    localparam int COUNT_W  = 7;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GET   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TEST  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic                      first_of_group;
        logic [GSIZE_W-1:0]        group_size;
        logic signed [VALUE_W-1:0] value;
        logic [KEY_W-1:0]          key;
        logic [ADDR_W-1:0]         address;
        logic [CMD_W-1:0]          cmd;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [HEAD_W-1:0]         head_address;
        logic signed [VALUE_W-1:0] data_out;
        logic                      is_free;
        logic [COUNT_W-1:0]        free_count;
    } result_t;

endpackage

[src/flcm_out_reg.sv]
// ============================================================================
// flcm_out_reg: result output register
// Holds one result beat so the engine can take the next item while the
// receiver stalls.
// ============================================================================
module flcm_out_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  flcm_pkg::result_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output flcm_pkg::result_t out_data
);

    logic              valid_reg;
    flcm_pkg::result_t data_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

endmodule

[src/flcm_engine.sv]
// ============================================================================
// flcm_engine: chain walker around the link and node memories
// Holds the link memory and the key/data memory, the free list registers
// and the allocation group state, and walks chains one node per cycle.
// ============================================================================
module flcm_engine
#(
    parameter int DEPTH    = 64,
    parameter int KEY_BITS = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  flcm_pkg::item_t   item,
    output logic              res_valid,
    input  logic              res_ready,
    output flcm_pkg::result_t res_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int PW = $clog2(DEPTH + 1);
    localparam int VW = (PW > flcm_pkg::GSIZE_W) ? PW : flcm_pkg::GSIZE_W;
    localparam int KW = (KEY_BITS < flcm_pkg::KEY_W) ? KEY_BITS : flcm_pkg::KEY_W;
    localparam int DW = flcm_pkg::VALUE_W;
    localparam int GW = flcm_pkg::GSIZE_W;

    localparam logic [PW-1:0] NULL_PTR  = PW'(DEPTH);
    localparam logic [PW-1:0] LAST_STEP = PW'(DEPTH - 1);
    localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_ALLOC_RD,
        S_ALLOC_TERM,
        S_FREE_WALK,
        S_COUNT_START,
        S_COUNT,
        S_FIND,
        S_TEST,
        S_EMIT
    } state_t;

    // Memories: link per node, and key with data word per node.
    logic [PW-1:0]    link_mem [DEPTH];
    logic [KW+DW-1:0] node_mem [DEPTH];

    logic [PW-1:0]    link_rdata_reg;
    logic [KW+DW-1:0] node_rdata_reg;

    state_t                         state_reg, state_next;
    flcm_pkg::item_t                item_reg, item_next;
    logic [AW-1:0]                  clr_reg, clr_next;
    logic [PW-1:0]                  free_head_reg, free_head_next;
    logic [PW-1:0]                  free_total_reg, free_total_next;
    logic [PW-1:0]                  group_head_reg, group_head_next;
    logic [PW-1:0]                  group_tail_reg, group_tail_next;
    logic [GW-1:0]                  group_left_reg, group_left_next;
    logic                           group_reject_reg, group_reject_next;
    logic [PW-1:0]                  x_reg, x_next;
    logic [PW-1:0]                  step_reg, step_next;
    logic [flcm_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic [PW-1:0]                  head_reg, head_next;
    logic signed [DW-1:0]           data_reg, data_next;
    logic                           is_free_reg, is_free_next;

    logic             link_we;
    logic [AW-1:0]    link_waddr;
    logic [PW-1:0]    link_wdata;
    logic             node_we;
    logic [AW-1:0]    node_waddr;
    logic [KW+DW-1:0] node_wdata;
    logic [PW-1:0]    rd_ptr;
    logic [AW-1:0]    rd_idx;

    logic [PW-1:0]    link_nxt;
    logic             link_nxt_ok;
    logic             head_ok;
    logic             tail_ok;
    logic [KW-1:0]    key_in;
    logic [KW-1:0]    node_key;
    logic [DW-1:0]    node_data;
    logic [VW-1:0]    addr_wide;
    logic             addr_ok;
    logic [PW-1:0]    addr_ptr;
    logic [GW-1:0]    gsize_eff;
    logic             no_room;
    logic             take;

    assign link_nxt    = (link_rdata_reg < NULL_PTR) ? link_rdata_reg : NULL_PTR;
    assign link_nxt_ok = link_nxt < NULL_PTR;
    assign head_ok     = free_head_reg < NULL_PTR;
    assign tail_ok     = group_tail_reg < NULL_PTR;
    assign key_in      = item_reg.key[KW-1:0];
    assign node_key    = node_rdata_reg[KW+DW-1:DW];
    assign node_data   = node_rdata_reg[DW-1:0];
    assign addr_wide   = VW'(item_reg.address);
    assign addr_ok     = addr_wide < VW'(DEPTH);
    assign addr_ptr    = PW'(item_reg.address);
    assign gsize_eff   = (item_reg.group_size == '0) ? GW'(1) : item_reg.group_size;
    assign no_room     = VW'(gsize_eff) > VW'(free_total_reg);
    assign rd_idx      = rd_ptr[AW-1:0];

    assign item_ready = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_EMIT);

    always_comb
    begin
        res_data.status       = status_reg;
        res_data.head_address = flcm_pkg::HEAD_W'(head_reg);
        res_data.data_out     = data_reg;
        res_data.is_free      = is_free_reg;
        res_data.free_count   = flcm_pkg::COUNT_W'(free_total_reg);
    end

    always_comb
    begin
        state_next        = state_reg;
        item_next         = item_reg;
        clr_next          = clr_reg;
        free_head_next    = free_head_reg;
        free_total_next   = free_total_reg;
        group_head_next   = group_head_reg;
        group_tail_next   = group_tail_reg;
        group_left_next   = group_left_reg;
        group_reject_next = group_reject_reg;
        x_next            = x_reg;
        step_next         = step_reg;
        status_next       = status_reg;
        head_next         = head_reg;
        data_next         = data_reg;
        is_free_next      = is_free_reg;
        link_we           = 1'b0;
        link_waddr        = x_reg[AW-1:0];
        link_wdata        = NULL_PTR;
        node_we           = 1'b0;
        node_waddr        = x_reg[AW-1:0];
        node_wdata        = node_rdata_reg;
        rd_ptr            = x_reg;
        take              = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                // One entry a cycle: link to the next entry, data word cleared.
                link_we    = 1'b1;
                link_waddr = clr_reg;
                link_wdata = PW'(clr_reg) + PW'(1);
                node_we    = 1'b1;
                node_waddr = clr_reg;
                node_wdata = '0;
                if (clr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_next  = item;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                status_next  = flcm_pkg::ST_OK;
                head_next    = NULL_PTR;
                data_next    = '0;
                is_free_next = 1'b0;
                state_next   = S_EMIT;
                step_next    = '0;
                case (item_reg.cmd) inside
                    flcm_pkg::CMD_ALLOC:
                    begin
                        if (item_reg.first_of_group)
                        begin
                            group_head_next   = NULL_PTR;
                            group_tail_next   = NULL_PTR;
                            group_reject_next = 1'b0;
                            if (no_room)
                            begin
                                group_left_next   = gsize_eff - GW'(1);
                                group_reject_next = (gsize_eff != GW'(1));
                                status_next       = flcm_pkg::ST_NO_SPACE;
                            end
                            else
                            begin
                                group_left_next = gsize_eff;
                                take            = 1'b1;
                            end
                        end
                        else if (group_left_reg == '0)
                        begin
                            state_next = S_IDLE;
                        end
                        else if (group_reject_reg)
                        begin
                            // A rejected group swallows its remaining items.
                            group_left_next = group_left_reg - GW'(1);
                            if (group_left_reg == GW'(1))
                            begin
                                group_reject_next = 1'b0;
                            end
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            take = 1'b1;
                        end

                        if (take)
                        begin
                            if (!head_ok)
                            begin
                                group_left_next = '0;
                                group_head_next = NULL_PTR;
                                group_tail_next = NULL_PTR;
                                status_next     = flcm_pkg::ST_NO_SPACE;
                            end
                            else
                            begin
                                x_next     = free_head_reg;
                                rd_ptr     = free_head_reg;
                                state_next = S_ALLOC_RD;
                            end
                        end
                    end

                    flcm_pkg::CMD_FREE:
                    begin
                        if (addr_ok)
                        begin
                            x_next     = addr_ptr;
                            rd_ptr     = addr_ptr;
                            state_next = S_FREE_WALK;
                        end
                    end

                    flcm_pkg::CMD_PUT, flcm_pkg::CMD_GET:
                    begin
                        if (addr_ok)
                        begin
                            x_next     = addr_ptr;
                            rd_ptr     = addr_ptr;
                            state_next = S_FIND;
                        end
                        else if (item_reg.cmd == flcm_pkg::CMD_GET)
                        begin
                            status_next = flcm_pkg::ST_NOT_FOUND;
                        end
                    end

                    flcm_pkg::CMD_TEST:
                    begin
                        if (addr_ok && head_ok)
                        begin
                            if (free_head_reg == addr_ptr)
                            begin
                                is_free_next = 1'b1;
                            end
                            else
                            begin
                                x_next     = free_head_reg;
                                rd_ptr     = free_head_reg;
                                state_next = S_TEST;
                            end
                        end
                    end

                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_ALLOC_RD:
            begin
                free_head_next = link_nxt;
                if (free_total_reg != '0)
                begin
                    free_total_next = free_total_reg - PW'(1);
                end
                if (tail_ok)
                begin
                    link_we    = 1'b1;
                    link_waddr = group_tail_reg[AW-1:0];
                    link_wdata = x_reg;
                end
                else
                begin
                    group_head_next = x_reg;
                end
                // Tag the node; its data word stays as it was.
                node_we         = 1'b1;
                node_wdata      = {key_in, node_data};
                group_tail_next = x_reg;
                group_left_next = group_left_reg - GW'(1);
                state_next      = S_ALLOC_TERM;
            end

            S_ALLOC_TERM:
            begin
                link_we    = 1'b1;
                link_wdata = NULL_PTR;
                if (group_left_reg == '0)
                begin
                    head_next       = group_head_reg;
                    group_head_next = NULL_PTR;
                    group_tail_next = NULL_PTR;
                    status_next     = flcm_pkg::ST_OK;
                    state_next      = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_FREE_WALK:
            begin
                if (link_nxt_ok && (step_reg < NULL_PTR))
                begin
                    x_next    = link_nxt;
                    rd_ptr    = link_nxt;
                    step_next = step_reg + PW'(1);
                end
                else
                begin
                    // Splice only a chain that ends; a loop is left alone.
                    if (!link_nxt_ok)
                    begin
                        link_we        = 1'b1;
                        link_wdata     = free_head_reg;
                        free_head_next = addr_ptr;
                    end
                    state_next = S_COUNT_START;
                end
            end

            S_COUNT_START:
            begin
                if (head_ok)
                begin
                    x_next     = free_head_reg;
                    rd_ptr     = free_head_reg;
                    step_next  = PW'(1);
                    state_next = S_COUNT;
                end
                else
                begin
                    free_total_next = '0;
                    state_next      = S_EMIT;
                end
            end

            S_COUNT:
            begin
                if (link_nxt_ok && (step_reg < NULL_PTR))
                begin
                    x_next    = link_nxt;
                    rd_ptr    = link_nxt;
                    step_next = step_reg + PW'(1);
                end
                else
                begin
                    free_total_next = step_reg;
                    state_next      = S_EMIT;
                end
            end

            S_FIND:
            begin
                if (node_key == key_in)
                begin
                    if (item_reg.cmd == flcm_pkg::CMD_PUT)
                    begin
                        node_we    = 1'b1;
                        node_wdata = {node_key, item_reg.value};
                    end
                    else
                    begin
                        data_next = node_data;
                    end
                    state_next = S_EMIT;
                end
                else if (link_nxt_ok && (step_reg != LAST_STEP))
                begin
                    x_next    = link_nxt;
                    rd_ptr    = link_nxt;
                    step_next = step_reg + PW'(1);
                end
                else
                begin
                    if (item_reg.cmd == flcm_pkg::CMD_GET)
                    begin
                        status_next = flcm_pkg::ST_NOT_FOUND;
                    end
                    state_next = S_EMIT;
                end
            end

            S_TEST:
            begin
                if (link_nxt_ok && (step_reg != LAST_STEP))
                begin
                    if (link_nxt == addr_ptr)
                    begin
                        is_free_next = 1'b1;
                        state_next   = S_EMIT;
                    end
                    else
                    begin
                        x_next    = link_nxt;
                        rd_ptr    = link_nxt;
                        step_next = step_reg + PW'(1);
                    end
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            item_reg         <= '0;
            clr_reg          <= '0;
            free_head_reg    <= '0;
            free_total_reg   <= NULL_PTR;
            group_head_reg   <= NULL_PTR;
            group_tail_reg   <= NULL_PTR;
            group_left_reg   <= '0;
            group_reject_reg <= 1'b0;
            x_reg            <= '0;
            step_reg         <= '0;
            status_reg       <= flcm_pkg::ST_OK;
            head_reg         <= NULL_PTR;
            data_reg         <= '0;
            is_free_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            item_reg         <= item_next;
            clr_reg          <= clr_next;
            free_head_reg    <= free_head_next;
            free_total_reg   <= free_total_next;
            group_head_reg   <= group_head_next;
            group_tail_reg   <= group_tail_next;
            group_left_reg   <= group_left_next;
            group_reject_reg <= group_reject_next;
            x_reg            <= x_next;
            step_reg         <= step_next;
            status_reg       <= status_next;
            head_reg         <= head_next;
            data_reg         <= data_next;
            is_free_reg      <= is_free_next;
        end
    end

    // Synchronous memories; read data is registered, valid in the cycle after the address.
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rdata_reg <= link_mem[rd_idx];
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        node_rdata_reg <= node_mem[rd_idx];
    end

endmodule

[src/free_list_chain_memory.sv]
// ============================================================================
// free_list_chain_memory: linked node store with a free list
// Top level: stream ports, beat packing, chain engine and output register.
// ============================================================================
// Usage:
//   Command beats enter on the s_ group; each gives at most one result beat
//   on the m_ group. Alloc items inside a group, ignored alloc items and
//   unused command codes give no result beat.
//   A command is taken only when the engine is idle, so one item is in
//   work at a time. An alloc item reads the free list head, links that
//   node into the group and ends the chain there; the first item of a
//   rejected group gives its no-space result without a read. Put and get
//   compare the nodes of the chain from the address; test walks the free
//   list; free walks the chain to its end, splices it onto the free list
//   and recounts the free list.
//   The walks read the link memory one node per cycle; that port sets the
//   rate. After reset the block writes the initial links and clears the
//   data words, with s_tready low.
//   A result beat waits in the output register while m_tready is low; the
//   next command is accepted meanwhile and stalls only when its own result
//   finds the register still full.
// ============================================================================
module free_list_chain_memory
#(
    parameter int DEPTH    = 64,
    parameter int KEY_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // address[5:0], key[37:6], value[69:38], group_size[76:70], zeros[79:77]
    input  logic [79:0] s_tdata,
    // cmd[2:0], first_of_group[3]
    input  logic [3:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // head_address[6:0], data_out[38:7], is_free[39], free_count[46:40],
    // zero[47]
    output logic [47:0] m_tdata,
    // status[1:0]
    output logic [1:0]  m_tuser
);

    flcm_pkg::item_t   item;
    flcm_pkg::result_t res_data;
    flcm_pkg::result_t out_data;
    logic              res_valid;
    logic              res_ready;

    always_comb
    begin
        item.cmd            = s_tuser[2:0];
        item.first_of_group = s_tuser[3];
        item.address        = s_tdata[5:0];
        item.key            = s_tdata[37:6];
        item.value          = signed'(s_tdata[69:38]);
        item.group_size     = s_tdata[76:70];
    end

    flcm_engine
    #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    )
    u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (s_tvalid),
        .item_ready (s_tready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

    flcm_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_data   (res_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {1'b0, out_data.free_count, out_data.is_free,
                      out_data.data_out, out_data.head_address};
    assign m_tuser = out_data.status;

    // The engine works on one item at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on two consecutive cycles");

    a_no_take_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !s_tready)
        else $error("input ready while a result is being handed over");

    a_head_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != flcm_pkg::ST_OK) |-> m_tdata[6:0] == 7'(DEPTH))
        else $error("chain head reported with an error status");

    a_no_space_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == flcm_pkg::ST_NO_SPACE) |-> m_tdata[39:7] == '0)
        else $error("data or free flag set on an insufficient-space result");

endmodule
